// ===== design/fssa_pkg.sv =====
// ----------------------------------------------------------------------------
// fssa_pkg
// shared widths and status codes of the free slot stack allocator
// ----------------------------------------------------------------------------
package fssa_pkg;

	localparam int SLOT_W   = 13;
	localparam int STATUS_W = 3;
	localparam int FUNC_W   = 1;
	localparam int APB_W    = 32;
	localparam int PADDR_W  = 3;

	// capacity after reset
	localparam logic [SLOT_W-1:0] CAP_RESET = SLOT_W'(4096);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_INVALID   = 3'd2,
		ST_ZERO_FREE = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	// register index of capacity
	localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== design/fssa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// fssa_stack_mem
// storage of freed slots: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module fssa_stack_mem #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [fssa_pkg::SLOT_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [fssa_pkg::SLOT_W-1:0] rdata
);

	logic [fssa_pkg::SLOT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/free_slot_stack_allocator_top.sv =====
// ----------------------------------------------------------------------------
// free_slot_stack_allocator_top
// hands out slots 1..min(capacity, MAX_SLOTS) from a lifo free list and takes them back
// ----------------------------------------------------------------------------
// usage:
//   request channel: drive func and slot with start high; a transfer happens
//   at the rising edge where start is high and busy is low. func 0 allocates,
//   func 1 frees the given slot.
//   result channel: granted_slot and status are shown for exactly one cycle
//   with done high, once the request transfer has passed through stage 1
//   and the result registers. the receiver cannot stall; it must take the
//   result in that cycle. busy is high while a request sits in stage 1, so
//   a new request is taken only after the last has left it; for a pop that
//   is the cycle in which the stack memory returns its registered read.
//   config: apb register capacity at byte address 0. writing it empties the
//   freed stack and restarts fresh slots at 1. write only while idle.
//   reset: capacity 4096, empty stack, next fresh slot 1; the stack memory
//   itself is not cleared, only entries below the stack depth are ever read.
// ----------------------------------------------------------------------------
module free_slot_stack_allocator_top #(
	parameter int MAX_SLOTS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            start,
	output logic                            busy,
	input  logic [fssa_pkg::FUNC_W-1:0]     func,
	input  logic [fssa_pkg::SLOT_W-1:0]     slot,
	// result
	output logic                            done,
	output logic [fssa_pkg::SLOT_W-1:0]     granted_slot,
	output logic [fssa_pkg::STATUS_W-1:0]   status,
	// config
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fssa_pkg::PADDR_W-1:0]    paddr,
	input  logic [fssa_pkg::APB_W-1:0]      pwdata,
	output logic [fssa_pkg::APB_W-1:0]      prdata,
	output logic                            pready
);

	localparam int ADDR_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int DEPTH_W = $clog2(MAX_SLOTS + 1);
	localparam int FRESH_W = fssa_pkg::SLOT_W + 1;
	// compare width wide enough for depth, fresh counter and capacity
	localparam int CMP_W   = (DEPTH_W > FRESH_W) ? DEPTH_W : FRESH_W;

	// config register
	logic [fssa_pkg::SLOT_W-1:0] capacity_q;
	logic                        cfg_wr;

	// list state
	logic [DEPTH_W-1:0] depth_q;
	logic [FRESH_W-1:0] fresh_q;

	// stage 1: waiting on the memory read
	logic                        valid_s1;
	logic                        pop_s1;
	logic [fssa_pkg::SLOT_W-1:0] granted_s1;
	fssa_pkg::status_t           status_s1;

	// result registers
	logic                        done_q;
	logic [fssa_pkg::SLOT_W-1:0] granted_q;
	fssa_pkg::status_t           status_q;

	// decision logic
	logic                        accept;
	logic [CMP_W-1:0]            cap_eff;
	logic [CMP_W-1:0]            cap_ext;
	logic [CMP_W-1:0]            fresh_ext;
	logic [CMP_W-1:0]            slot_ext;
	logic                        stack_empty;
	logic                        stack_full;
	logic                        do_pop;
	logic                        do_push;
	logic                        do_fresh;
	fssa_pkg::status_t           status_d;
	logic [DEPTH_W-1:0]          depth_dec;
	logic [fssa_pkg::SLOT_W-1:0] mem_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready
		& (paddr[fssa_pkg::PADDR_W-1] == fssa_pkg::REG_CAPACITY);

	always_comb begin
		prdata = '0;
		if (paddr[fssa_pkg::PADDR_W-1] == fssa_pkg::REG_CAPACITY) begin
			prdata = {{(fssa_pkg::APB_W - fssa_pkg::SLOT_W){1'b0}}, capacity_q};
		end
	end

	assign accept = start & ~busy;
	assign busy   = valid_s1;

	// effective capacity is min(capacity, MAX_SLOTS)
	assign cap_ext   = CMP_W'(capacity_q);
	assign cap_eff   = (cap_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : cap_ext;
	assign fresh_ext = CMP_W'(fresh_q);
	assign slot_ext  = CMP_W'(slot);

	assign stack_empty = (depth_q == '0);
	assign stack_full  = (depth_q == DEPTH_W'(MAX_SLOTS));
	assign depth_dec   = depth_q - DEPTH_W'(1);

	always_comb begin
		do_pop   = 1'b0;
		do_push  = 1'b0;
		do_fresh = 1'b0;
		status_d = fssa_pkg::ST_OK;
		if (func == fssa_pkg::FN_ALLOC) begin
			if (!stack_empty) begin
				do_pop = 1'b1;
			end else if (fresh_ext <= cap_eff) begin
				do_fresh = 1'b1;
			end else begin
				status_d = fssa_pkg::ST_EXHAUSTED;
			end
		end else begin
			// zero free is checked before the capacity bound
			if (slot == '0) begin
				status_d = fssa_pkg::ST_ZERO_FREE;
			end else if (slot_ext > cap_eff) begin
				status_d = fssa_pkg::ST_INVALID;
			end else if (stack_full) begin
				status_d = fssa_pkg::ST_OVERFLOW;
			end else begin
				do_push = 1'b1;
			end
		end
	end

	fssa_stack_mem #(
		.DEPTH  (MAX_SLOTS),
		.ADDR_W (ADDR_W)
	) u_stack_mem (
		.clk   (clk),
		.we    (accept & do_push),
		.waddr (depth_q[ADDR_W-1:0]),
		.wdata (slot),
		.re    (accept & do_pop),
		.raddr (depth_dec[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// capacity register and list state; a capacity write restarts the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fssa_pkg::CAP_RESET;
			depth_q    <= '0;
			fresh_q    <= FRESH_W'(1);
		end else if (cfg_wr) begin
			capacity_q <= pwdata[fssa_pkg::SLOT_W-1:0];
			depth_q    <= '0;
			fresh_q    <= FRESH_W'(1);
		end else if (accept) begin
			if (do_pop) begin
				depth_q <= depth_dec;
			end else if (do_push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end
			if (do_fresh) begin
				fresh_q <= fresh_q + FRESH_W'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1     <= do_pop;
			granted_s1 <= do_fresh ? fresh_q[fssa_pkg::SLOT_W-1:0] : '0;
			status_s1  <= status_d;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload, popped entry comes straight from the memory
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			granted_q <= pop_s1 ? mem_rdata : granted_s1;
			status_q  <= status_s1;
		end
	end

	assign done         = done_q;
	assign granted_slot = granted_q;
	assign status       = status_q;

	// every result follows a request transfer, registered through stage 1 and the result strobe
	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without a request");

	// no new transfer while any request is outstanding in stage 1
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !accept)
		else $error("request taken while busy");

	// stack depth stays within the memory
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_SLOTS))
		else $error("stack depth above memory size");

	// a failed request never grants a slot
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fssa_pkg::ST_OK)) |-> (granted_slot == '0))
		else $error("slot granted on a failed request");

	// fresh counter never drops below one
	a_fresh_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q != '0)
		else $error("fresh slot counter at zero");

endmodule

// ===== tb/sv/free_slot_stack_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// free_slot_stack_allocator_checker
// predicts every grant of the slot allocator and compares the results
// ----------------------------------------------------------------------------
module free_slot_stack_allocator_checker
	import fssa_pkg::*;
#(
	parameter int MAX_SLOTS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                done,
	input  logic [SLOT_W-1:0]   granted_slot,
	input  logic [STATUS_W-1:0] status,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]    pwdata,
	input  logic [APB_W-1:0]    prdata,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);

	typedef struct packed {
		logic [SLOT_W-1:0] granted;
		status_t           code;
	} grant_t;

	logic [SLOT_W-1:0] cap_reg;
	logic [SLOT_W-1:0] freed_slots [MAX_SLOTS];
	int unsigned       freed_depth;
	int unsigned       fresh_slot;
	grant_t            grant_q [$];
	grant_t            want;
	int unsigned       shown;

	function automatic int unsigned usable_slots();
		return (cap_reg > MAX_SLOTS) ? MAX_SLOTS : cap_reg;
	endfunction

	// lifo of freed slots above a counter of never-issued slots
	function automatic grant_t predict_grant(input func_t f, input logic [SLOT_W-1:0] s);
		grant_t      g;
		int unsigned lim;
		lim       = usable_slots();
		g.granted = '0;
		g.code    = ST_OK;
		if (f == FN_ALLOC) begin
			if (freed_depth > 0) begin
				freed_depth--;
				g.granted = freed_slots[freed_depth];
			end else if (fresh_slot <= lim) begin
				g.granted = SLOT_W'(fresh_slot);
				fresh_slot++;
			end else begin
				g.code = ST_EXHAUSTED;
			end
		end else if (s == '0) begin
			g.code = ST_ZERO_FREE;
		end else if (s > lim) begin
			g.code = ST_INVALID;
		end else if (freed_depth >= MAX_SLOTS) begin
			g.code = ST_OVERFLOW;
		end else begin
			freed_slots[freed_depth] = s;
			freed_depth++;
		end
		return g;
	endfunction

	task automatic report(input string what);
		fail_count++;
		if (shown < 40) begin
			$display("%0t ns mismatch: %s", $realtime, what);
			shown++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg     = CAP_RESET;
			freed_depth = 0;
			fresh_slot  = 1;
			fail_count  = 0;
			shown       = 0;
			grant_q.delete();
			pending    <= 0;
		end else begin
			if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
				if (pwrite) begin
					cap_reg     = pwdata[SLOT_W-1:0];
					freed_depth = 0;
					fresh_slot  = 1;
				end else if (prdata !== APB_W'(cap_reg)) begin
					report($sformatf("capacity read %0d, expected %0d", prdata, cap_reg));
				end
			end
			if (done) begin
				if (grant_q.size() == 0) begin
					report($sformatf("result slot %0d status %0d with no request outstanding",
						granted_slot, status));
				end else begin
					want = grant_q.pop_front();
					if (granted_slot !== want.granted)
						report($sformatf("granted_slot %0d, expected %0d",
							granted_slot, want.granted));
					if (status !== want.code)
						report($sformatf("status %0d, expected %0d", status, want.code));
				end
			end
			if (start && !busy)
				grant_q.push_back(predict_grant(func_t'(func), slot));
			pending <= grant_q.size();
		end
	end

endmodule

// ===== tb/sv/free_slot_stack_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// free_slot_stack_allocator_top_tb
// drives allocate and free requests and capacity writes into the allocator;
// a checker beside the block predicts every grant and compares the results
// ----------------------------------------------------------------------------
module free_slot_stack_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fssa_pkg::*;

	localparam int MAX_SLOTS  = 4096;
	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASES     = 10;
	localparam int PHASE_REQS = 108;
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [SLOT_W-1:0]   slot;
	logic                done;
	logic [SLOT_W-1:0]   granted_slot;
	logic [STATUS_W-1:0] status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [APB_W-1:0]    pwdata;
	logic [APB_W-1:0]    prdata;
	logic                pready;

	int                  fail_count;
	int                  pending;
	bit                  gaps_on;
	int unsigned         quiet_cycles = 0;
	// slots currently handed out, used to build well-formed frees
	logic [SLOT_W-1:0]   held_slots [$];

	always #4ns clk = ~clk;

	free_slot_stack_allocator_top #(
		.MAX_SLOTS(MAX_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.done        (done),
		.granted_slot(granted_slot),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	free_slot_stack_allocator_checker #(
		.MAX_SLOTS(MAX_SLOTS)
	) grant_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.done        (done),
		.granted_slot(granted_slot),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// collect granted slots mid-cycle, away from the edge where requests change
	always @(negedge clk) begin
		if (arst_n && done === 1'b1 && status == ST_OK && granted_slot != '0)
			held_slots.push_back(granted_slot);
	end

	// watchdog: any request, result or register transfer counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("** free_slot_stack_allocator_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request transfer; may first drop start for a random gap
	task automatic send(input func_t f, input logic [SLOT_W-1:0] s);
		if (gaps_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		func  <= f;
		slot  <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// stop requesting and wait until every result has come back
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// optional capacity write, then a read back of the register
	task automatic program_capacity(input bit do_write, input logic [APB_W-1:0] value);
		wait_idle();
		psel  <= 1'b1;
		paddr <= CAPACITY_ADDR;
		if (do_write) begin
			pwrite  <= 1'b1;
			pwdata  <= value;
			penable <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
		end
		// read setup follows the write access directly
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		held_slots.delete();
	endtask

	// mostly allocates and frees of held slots, the rest malformed frees
	task automatic random_request(input int unsigned lim);
		int unsigned       pick;
		int unsigned       idx;
		logic [SLOT_W-1:0] s;
		pick = $urandom_range(99);
		if (pick < 45 || (pick < 80 && held_slots.size() == 0)) begin
			send(FN_ALLOC, SLOT_W'($urandom));
		end else if (pick < 80) begin
			idx = $urandom_range(held_slots.size() - 1);
			s   = held_slots[idx];
			held_slots.delete(idx);
			send(FN_FREE, s);
		end else begin
			case ($urandom_range(3))
				0: s = '0;
				1: s = SLOT_W'($urandom);
				2: s = SLOT_W'($urandom_range(lim + 1, 8191));
				// double free or free of a slot never issued
				default: s = (lim == 0) ? SLOT_W'(1) : SLOT_W'($urandom_range(1, lim));
			endcase
			send(FN_FREE, s);
		end
	endtask

	initial begin
		logic [APB_W-1:0] cap;
		int unsigned      lim;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		func    <= FN_ALLOC;
		slot    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		gaps_on  = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of capacity
		program_capacity(1'b0, '0);

		// fresh slots in order, fallback and out-of-range frees, lifo reuse
		send(FN_ALLOC, '0);
		send(FN_ALLOC, 13'h1fff);
		send(FN_FREE, '0);
		send(FN_FREE, 13'd4097);
		send(FN_FREE, 13'h1fff);
		send(FN_FREE, 13'd4096);
		send(FN_FREE, 13'd4096);
		send(FN_ALLOC, '0);
		send(FN_ALLOC, '0);
		send(FN_FREE, 13'd2);
		send(FN_FREE, 13'd1);
		send(FN_ALLOC, '0);
		send(FN_ALLOC, '0);
		send(FN_ALLOC, '0);

		// single slot: exhaustion and the bound on frees
		program_capacity(1'b1, 32'd1);
		send(FN_ALLOC, '0);
		send(FN_ALLOC, '0);
		send(FN_FREE, 13'd2);
		send(FN_FREE, 13'd1);
		send(FN_ALLOC, '0);

		// zero capacity: everything falls back or is invalid
		program_capacity(1'b1, 32'd0);
		send(FN_ALLOC, '0);
		send(FN_FREE, 13'd1);
		send(FN_FREE, '0);

		// capacity above the stack size is clamped
		program_capacity(1'b1, 32'd8191);
		send(FN_FREE, 13'd4096);
		send(FN_FREE, 13'd4097);
		send(FN_ALLOC, '0);

		// stack a run of frees, then pop part of it back in lifo order
		program_capacity(1'b1, 32'd4096);
		repeat (32) send(FN_FREE, SLOT_W'($urandom_range(1, 4096)));
		send(FN_FREE, '0);
		send(FN_FREE, 13'd5000);
		repeat (8) send(FN_ALLOC, SLOT_W'($urandom));
		repeat (9) send(FN_FREE, SLOT_W'($urandom_range(1, 4096)));

		// random phases, each under its own capacity
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = 32'd1;
				1: cap = 32'd2;
				2: cap = $urandom_range(3, 12);
				3: cap = $urandom_range(13, 60);
				4: cap = 32'd4096;
				5: cap = $urandom_range(4097, 8191);
				6: cap = 32'd4095;
				// upper data bits are not part of the register
				7: cap = ($urandom() & ~32'h1fff) | $urandom_range(1, 4096);
				8: cap = 32'd0;
				default: cap = $urandom_range(2, 8);
			endcase
			lim = (cap[SLOT_W-1:0] > MAX_SLOTS) ? MAX_SLOTS : cap[SLOT_W-1:0];
			program_capacity(1'b1, cap);
			// one phase runs back to back with no gaps at all
			gaps_on = (p != 4);
			repeat (PHASE_REQS) random_request(lim);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("** free_slot_stack_allocator_top: PASSED **");
		end else begin
			$display("** free_slot_stack_allocator_top: FAILED **");
		end
		$finish;
	end

endmodule
